// ----- src/psbc_pkg.sv -----
// Shared types and constants for the point-set bounds and centroid block.
package psbc_pkg;

   localparam int COORD_W = 16;
   localparam int POS_W   = 10;
   localparam int COUNT_W = 11;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // empty-set sentinels
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic                      func;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [POS_W-1:0]          position;
   } req_type;

   typedef struct packed {
      logic                      accepted;
      logic [COUNT_W-1:0]        count;
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] min_z;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] max_y;
      logic signed [COORD_W-1:0] max_z;
      logic signed [COORD_W-1:0] mean_x;
      logic signed [COORD_W-1:0] mean_y;
      logic signed [COORD_W-1:0] mean_z;
      logic [1:0]                major_axis;
   } rsp_type;

   // one stored point
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

endpackage

// ----- src/psbc_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
module psbc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/psbc_div.sv -----
// Shared signed-by-unsigned divider, restoring, one quotient bit per cycle.
module psbc_div #(
   parameter int DVD_W = 27,
   parameter int DVS_W = 11,
   parameter int Q_W   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0]        divisor,
   output logic                    done,
   output logic signed [Q_W-1:0]   quotient
);

   localparam int STEP_W = $clog2(DVD_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DVD_W-1:0]  q_ff, q_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;

   logic [DVD_W-1:0]  dvd_mag;
   logic [DVS_W:0]    rem_sh;
   logic [DVS_W:0]    rem_diff;
   logic              fits;
   logic [Q_W-1:0]    q_mag;

   // magnitude of the dividend; the most negative value maps onto 2^(DVD_W-1)
   assign dvd_mag = dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;

   // one restoring step
   assign rem_sh   = {rem_ff, q_ff[DVD_W-1]};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};
   assign fits     = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      step_in = step_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[DVD_W-1];
         step_in = '0;
         q_in    = dvd_mag;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         q_in    = {q_ff[DVD_W-2:0], fits};
         rem_in  = fits ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      step_ff <= step_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   // quotient truncates toward zero: apply the sign to the magnitude
   assign q_mag    = q_ff[Q_W-1:0];
   assign quotient = neg_ff ? (~q_mag + 1'b1) : q_mag;
   assign done     = done_ff;

endmodule

// ----- src/point_set_bounds_and_centroid.sv -----
// An insert's result waits on its three means, each taken in turn from the shared divider
// that yields one quotient bit per cycle.
// A remove first walks the remaining points through the store's read port, then drains.
// One item at a time: requests stall until the result is loaded; a finished result may wait in
// the output register while the next item is taken. Reset empties the set, puts the bounds at
// their sentinels and clears the sums; the point store is not cleared.
module point_set_bounds_and_centroid #(
   parameter int MAX_POINTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  psbc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output psbc_pkg::rsp_type rsp_data
);

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int SUM_W  = psbc_pkg::COORD_W + CNT_W;
   localparam int CMP_W  = CNT_W + psbc_pkg::POS_W;
   localparam int SPAN_W = psbc_pkg::COORD_W + 1;
   localparam int PT_W   = $bits(psbc_pkg::point_type);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_WALK     = 6'b000010,
      ST_DRAIN    = 6'b000100,
      ST_DIV_GO   = 6'b001000,
      ST_DIV_WAIT = 6'b010000,
      ST_DONE     = 6'b100000
   } state_type;

   state_type                           state_ff, state_in;
   logic [CNT_W-1:0]                    cnt_ff, cnt_in;
   logic [CNT_W-1:0]                    pos_ff, pos_in;
   logic [CNT_W-1:0]                    walk_ff, walk_in;
   logic [CNT_W-1:0]                    rd_idx_ff, rd_idx_in;
   logic                                rd_v_ff, rd_v_in;
   logic                                ok_ff, ok_in;
   logic [1:0]                          axis_ff, axis_in;
   logic signed [psbc_pkg::COORD_W-1:0] lo_ff [3];
   logic signed [psbc_pkg::COORD_W-1:0] lo_in [3];
   logic signed [psbc_pkg::COORD_W-1:0] hi_ff [3];
   logic signed [psbc_pkg::COORD_W-1:0] hi_in [3];
   logic signed [SUM_W-1:0]             sum_ff [3];
   logic signed [SUM_W-1:0]             sum_in [3];
   logic signed [psbc_pkg::COORD_W-1:0] mean_ff [3];
   logic signed [psbc_pkg::COORD_W-1:0] mean_in [3];
   logic                                rsp_valid_ff, rsp_valid_in;
   psbc_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   logic                                req_fire;
   logic                                is_insert;
   logic                                ins_ok;
   logic                                rem_ok;
   logic                                rsp_load;
   logic                                fold_en;
   logic signed [psbc_pkg::COORD_W-1:0] fold_c [3];
   logic signed [psbc_pkg::COORD_W-1:0] in_c [3];
   logic signed [psbc_pkg::COORD_W-1:0] rd_c [3];
   logic signed [SPAN_W-1:0]            span [3];
   logic [1:0]                          major;

   psbc_pkg::point_type                 in_pt;
   psbc_pkg::point_type                 rd_pt;
   logic                                ram_we;
   logic [ADDR_W-1:0]                   ram_wr_addr;
   logic [PT_W-1:0]                     ram_wr_data;
   logic [ADDR_W-1:0]                   ram_rd_addr;
   logic [PT_W-1:0]                     ram_rd_data;
   logic [CNT_W-1:0]                    walk_src;

   logic                                div_start;
   logic                                div_done;
   logic signed [psbc_pkg::COORD_W-1:0] div_quo;

   // input handshake and validity checks
   assign req_stall = state_ff != ST_IDLE;
   assign req_fire  = req_valid && !req_stall;
   assign is_insert = req_data.func == psbc_pkg::FUNC_INSERT;
   assign ins_ok    = cnt_ff < CNT_W'(MAX_POINTS);
   assign rem_ok    = CMP_W'(req_data.position) < CMP_W'(cnt_ff);

   assign in_pt.x = req_data.x;
   assign in_pt.y = req_data.y;
   assign in_pt.z = req_data.z;
   assign in_c[0] = req_data.x;
   assign in_c[1] = req_data.y;
   assign in_c[2] = req_data.z;

   assign rd_pt   = psbc_pkg::point_type'(ram_rd_data);
   assign rd_c[0] = rd_pt.x;
   assign rd_c[1] = rd_pt.y;
   assign rd_c[2] = rd_pt.z;

   // store: insert appends at the count; the walk writes each later point one place down
   assign walk_src    = (walk_ff < pos_ff) ? walk_ff : walk_ff + 1'b1;
   assign ram_rd_addr = walk_src[ADDR_W-1:0];
   assign ram_we      = (req_fire && is_insert && ins_ok) || (rd_v_ff && rd_idx_ff >= pos_ff);
   assign ram_wr_addr = (state_ff == ST_IDLE) ? cnt_ff[ADDR_W-1:0] : rd_idx_ff[ADDR_W-1:0];
   assign ram_wr_data = (state_ff == ST_IDLE) ? PT_W'(in_pt) : ram_rd_data;

   psbc_ram #(
      .WIDTH (PT_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   psbc_div #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W),
      .Q_W   (psbc_pkg::COORD_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff[axis_ff]),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // spans and major axis: Z or Y only when strictly widest, else X (X wins every tie)
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         span[a] = SPAN_W'(hi_ff[a]) - SPAN_W'(lo_ff[a]);
      end
      if (span[2] > span[1] && span[2] > span[0]) begin
         major = psbc_pkg::AXIS_Z;
      end else if (span[1] > span[2] && span[1] > span[0]) begin
         major = psbc_pkg::AXIS_Y;
      end else begin
         major = psbc_pkg::AXIS_X;
      end
   end

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      walk_in   = walk_ff;
      rd_idx_in = rd_idx_ff;
      rd_v_in   = 1'b0;
      ok_in     = ok_ff;
      axis_in   = axis_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      sum_in    = sum_ff;
      mean_in   = mean_ff;
      div_start = 1'b0;
      fold_en   = 1'b0;
      fold_c    = rd_c;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               axis_in  = psbc_pkg::AXIS_X;
               state_in = ST_DIV_GO;
               if (is_insert) begin
                  ok_in = ins_ok;
                  if (ins_ok) begin
                     cnt_in  = cnt_ff + 1'b1;
                     fold_en = 1'b1;
                     fold_c  = in_c;
                  end
               end else begin
                  ok_in = rem_ok;
                  if (rem_ok) begin
                     cnt_in  = cnt_ff - 1'b1;
                     pos_in  = CNT_W'(req_data.position);
                     walk_in = '0;
                     for (int a = 0; a < 3; a++) begin
                        lo_in[a]  = psbc_pkg::COORD_MAX;
                        hi_in[a]  = psbc_pkg::COORD_MIN;
                        sum_in[a] = '0;
                     end
                     if (cnt_ff != CNT_W'(1)) begin
                        state_in = ST_WALK;
                     end
                  end
               end
            end
         end
         ST_WALK: begin
            rd_v_in   = 1'b1;
            rd_idx_in = walk_ff;
            walk_in   = walk_ff + 1'b1;
            if (walk_ff == cnt_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            if (cnt_ff == '0) begin
               for (int a = 0; a < 3; a++) begin
                  mean_in[a] = '0;
               end
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               mean_in[axis_ff] = div_quo;
               if (axis_ff == psbc_pkg::AXIS_Z) begin
                  state_in = ST_DONE;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // walk beats fold in as their read data lands
      if (rd_v_ff) begin
         fold_en = 1'b1;
         fold_c  = rd_c;
      end

      // fold one point into bounds and sums
      if (fold_en) begin
         for (int a = 0; a < 3; a++) begin
            if (fold_c[a] < lo_ff[a]) begin
               lo_in[a] = fold_c[a];
            end
            if (fold_c[a] > hi_ff[a]) begin
               hi_in[a] = fold_c[a];
            end
            sum_in[a] = sum_ff[a] + SUM_W'(fold_c[a]);
         end
      end
   end

   // result register
   always_comb begin
      rsp_data_in            = rsp_data_ff;
      rsp_valid_in           = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.accepted   = ok_ff;
         rsp_data_in.count      = psbc_pkg::COUNT_W'(cnt_ff);
         rsp_data_in.min_x      = lo_ff[0];
         rsp_data_in.min_y      = lo_ff[1];
         rsp_data_in.min_z      = lo_ff[2];
         rsp_data_in.max_x      = hi_ff[0];
         rsp_data_in.max_y      = hi_ff[1];
         rsp_data_in.max_z      = hi_ff[2];
         rsp_data_in.mean_x     = mean_ff[0];
         rsp_data_in.mean_y     = mean_ff[1];
         rsp_data_in.mean_z     = mean_ff[2];
         rsp_data_in.major_axis = major;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            lo_ff[a]  <= psbc_pkg::COORD_MAX;
            hi_ff[a]  <= psbc_pkg::COORD_MIN;
            sum_ff[a] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_v_ff      <= rd_v_in;
         rsp_valid_ff <= rsp_valid_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         sum_ff       <= sum_in;
      end
      pos_ff      <= pos_in;
      walk_ff     <= walk_in;
      rd_idx_ff   <= rd_idx_in;
      ok_ff       <= ok_in;
      axis_ff     <= axis_in;
      mean_ff     <= mean_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // the set never grows past the store
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_POINTS))
      else $error("point count above store size");

   // a result appears only out of the completion state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside completion");

   // divider finishes only while the sequencer waits on it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider done out of sequence");

   // walk beats stay inside the shrunken set
   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      rd_v_ff |-> rd_idx_ff < cnt_ff)
      else $error("walk beat beyond point count");
`endif

endmodule

// ----- bench/point_set_bounds_and_centroid_tb.sv -----
// Self-checking testbench for the point-set bounds and centroid block.
`timescale 1ns / 1ps

module point_set_bounds_and_centroid_tb;

   localparam int STORE_DEPTH  = 1024;
   localparam int RANDOM_ITEMS = 400;
   localparam int TAIL_CYCLES  = 1200;       // longer than a remove over a full store
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int DIR_ROWS     = 21;

   // one row of stimulus; want is used only where fixed is set
   typedef struct {
      psbc_pkg::req_type item;
      bit                fixed;
      psbc_pkg::rsp_type want;
   } stim_row_type;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   psbc_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   psbc_pkg::rsp_type rsp_data;

   stim_row_type      pending_items[$];
   psbc_pkg::rsp_type expected_summaries[$];
   stim_row_type      on_wire;
   int      planned_count  = 0;
   int      send_idle_pct  = 0;
   int      recv_stall_pct = 0;
   int      mismatches     = 0;
   int      cycle_count    = 0;

   // predictor state: points held, bounds and sums
   psbc_pkg::point_type held_pts [STORE_DEPTH];
   int        held_count = 0;
   longint    held_lo [3];
   longint    held_hi [3];
   longint    held_sums [3];

   point_set_bounds_and_centroid #(
      .MAX_POINTS(STORE_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_bounds();
      for (int a = 0; a < 3; a++) begin
         held_lo[a]   = psbc_pkg::COORD_MAX;
         held_hi[a]   = psbc_pkg::COORD_MIN;
         held_sums[a] = 0;
      end
   endfunction

   function automatic void fold_point(psbc_pkg::point_type p);
      longint c [3];
      c[0] = p.x;
      c[1] = p.y;
      c[2] = p.z;
      for (int a = 0; a < 3; a++) begin
         if (c[a] < held_lo[a]) held_lo[a] = c[a];
         if (c[a] > held_hi[a]) held_hi[a] = c[a];
         held_sums[a] += c[a];
      end
   endfunction

   // applies one item to the held set and returns the summary it should produce
   function automatic psbc_pkg::rsp_type predict_summary(psbc_pkg::req_type r);
      psbc_pkg::rsp_type s;
      logic    ok;
      longint  mean [3];
      longint  span [3];
      ok = 1'b0;
      if (r.func == psbc_pkg::FUNC_INSERT) begin
         if (held_count < STORE_DEPTH) begin
            held_pts[held_count].x = r.x;
            held_pts[held_count].y = r.y;
            held_pts[held_count].z = r.z;
            fold_point(held_pts[held_count]);
            held_count++;
            ok = 1'b1;
         end
      end else if (r.position < held_count) begin
         // close the gap, then rebuild bounds and sums from what is left
         for (int i = r.position; i < held_count - 1; i++) held_pts[i] = held_pts[i + 1];
         held_count--;
         clear_bounds();
         for (int i = 0; i < held_count; i++) fold_point(held_pts[i]);
         ok = 1'b1;
      end
      for (int a = 0; a < 3; a++) begin
         mean[a] = (held_count == 0) ? 0 : held_sums[a] / held_count;
         span[a] = held_hi[a] - held_lo[a];
      end
      s.accepted = ok;
      s.count    = held_count[psbc_pkg::COUNT_W-1:0];
      s.min_x    = held_lo[0][psbc_pkg::COORD_W-1:0];
      s.min_y    = held_lo[1][psbc_pkg::COORD_W-1:0];
      s.min_z    = held_lo[2][psbc_pkg::COORD_W-1:0];
      s.max_x    = held_hi[0][psbc_pkg::COORD_W-1:0];
      s.max_y    = held_hi[1][psbc_pkg::COORD_W-1:0];
      s.max_z    = held_hi[2][psbc_pkg::COORD_W-1:0];
      s.mean_x   = mean[0][psbc_pkg::COORD_W-1:0];
      s.mean_y   = mean[1][psbc_pkg::COORD_W-1:0];
      s.mean_z   = mean[2][psbc_pkg::COORD_W-1:0];
      if (span[2] > span[1] && span[2] > span[0])
         s.major_axis = psbc_pkg::AXIS_Z;
      else if (span[1] > span[2] && span[1] > span[0])
         s.major_axis = psbc_pkg::AXIS_Y;
      else
         s.major_axis = psbc_pkg::AXIS_X;
      return s;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic psbc_pkg::rsp_type summary(int acc, int cnt, int mnx, int mny, int mnz,
                                       int mxx, int mxy, int mxz, int avx, int avy, int avz,
                                       logic [1:0] axis);
      psbc_pkg::rsp_type s;
      s.accepted   = acc[0];
      s.count      = cnt[psbc_pkg::COUNT_W-1:0];
      s.min_x      = mnx[psbc_pkg::COORD_W-1:0];
      s.min_y      = mny[psbc_pkg::COORD_W-1:0];
      s.min_z      = mnz[psbc_pkg::COORD_W-1:0];
      s.max_x      = mxx[psbc_pkg::COORD_W-1:0];
      s.max_y      = mxy[psbc_pkg::COORD_W-1:0];
      s.max_z      = mxz[psbc_pkg::COORD_W-1:0];
      s.mean_x     = avx[psbc_pkg::COORD_W-1:0];
      s.mean_y     = avy[psbc_pkg::COORD_W-1:0];
      s.mean_z     = avz[psbc_pkg::COORD_W-1:0];
      s.major_axis = axis;
      return s;
   endfunction

   function automatic stim_row_type mk_row(logic f, int x, int y, int z, int pos,
                                           bit fixed, psbc_pkg::rsp_type want);
      stim_row_type r;
      r.item.func     = f;
      r.item.x        = x[psbc_pkg::COORD_W-1:0];
      r.item.y        = y[psbc_pkg::COORD_W-1:0];
      r.item.z        = z[psbc_pkg::COORD_W-1:0];
      r.item.position = pos[psbc_pkg::POS_W-1:0];
      r.fixed         = fixed;
      r.want          = want;
      return r;
   endfunction

   // mix of full range, near zero, the two extremes and a moderate spread
   function automatic logic signed [psbc_pkg::COORD_W-1:0] rand_coord();
      case ($urandom_range(3))
         0:       return psbc_pkg::COORD_W'($urandom);
         1:       return psbc_pkg::COORD_W'(int'($urandom_range(40)) - 20);
         2:       return $urandom_range(1) ? psbc_pkg::COORD_MAX : psbc_pkg::COORD_MIN;
         default: return psbc_pkg::COORD_W'(int'($urandom_range(2000)) - 1000);
      endcase
   endfunction

   task automatic set_idling(int phase);
      case (phase)
         0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
         default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
   endtask

   // hands a row to the driver and tracks the count the set will have once it is applied
   task automatic queue_item(stim_row_type r, output bit applied);
      while (pending_items.size() >= 2) @(negedge clock);
      pending_items.insert(pending_items.size(), r);
      if (r.item.func == psbc_pkg::FUNC_INSERT)
         applied = planned_count < STORE_DEPTH;
      else
         applied = r.item.position < planned_count;
      if (applied) planned_count += (r.item.func == psbc_pkg::FUNC_INSERT) ? 1 : -1;
   endtask

   task automatic queue_random(logic f, int pos, output bit applied);
      queue_item(mk_row(f, rand_coord(), rand_coord(), rand_coord(), pos, 1'b0, '0), applied);
   endtask

   task automatic report_mismatch(string what, logic signed [31:0] got,
                                  logic signed [31:0] want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   // ---------------------------------------------------------------- request driver

   always @(posedge clock) begin
      bit                fire;
      psbc_pkg::rsp_type predicted;
      fire = req_valid && !req_stall;
      if (fire) begin
         predicted = predict_summary(on_wire.item);
         expected_summaries.insert(expected_summaries.size(),
                                   on_wire.fixed ? on_wire.want : predicted);
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || fire) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            on_wire = pending_items.pop_front();
            req_valid <= 1'b1;
            req_data  <= on_wire.item;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- result checker

   always @(posedge clock) begin
      psbc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_summaries.size() == 0) begin
            report_mismatch("unexpected result beat, count", rsp_data.count, -1);
         end else begin
            want = expected_summaries.pop_front();
            if (rsp_data.accepted !== want.accepted)
               report_mismatch("accepted", rsp_data.accepted, want.accepted);
            if (rsp_data.count !== want.count)
               report_mismatch("count", rsp_data.count, want.count);
            if (rsp_data.min_x !== want.min_x)
               report_mismatch("min_x", rsp_data.min_x, want.min_x);
            if (rsp_data.min_y !== want.min_y)
               report_mismatch("min_y", rsp_data.min_y, want.min_y);
            if (rsp_data.min_z !== want.min_z)
               report_mismatch("min_z", rsp_data.min_z, want.min_z);
            if (rsp_data.max_x !== want.max_x)
               report_mismatch("max_x", rsp_data.max_x, want.max_x);
            if (rsp_data.max_y !== want.max_y)
               report_mismatch("max_y", rsp_data.max_y, want.max_y);
            if (rsp_data.max_z !== want.max_z)
               report_mismatch("max_z", rsp_data.max_z, want.max_z);
            if (rsp_data.mean_x !== want.mean_x)
               report_mismatch("mean_x", rsp_data.mean_x, want.mean_x);
            if (rsp_data.mean_y !== want.mean_y)
               report_mismatch("mean_y", rsp_data.mean_y, want.mean_y);
            if (rsp_data.mean_z !== want.mean_z)
               report_mismatch("mean_z", rsp_data.mean_z, want.mean_z);
            if (rsp_data.major_axis !== want.major_axis)
               report_mismatch("major_axis", rsp_data.major_axis, want.major_axis);
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- test sequence

   initial begin
      stim_row_type      dir_table [DIR_ROWS];
      psbc_pkg::rsp_type empty_reject;
      bit      applied;
      int      applied_n;
      int      ins_share;
      int      pos;

      clear_bounds();
      empty_reject = summary(0, 0, psbc_pkg::COORD_MAX, psbc_pkg::COORD_MAX,
                             psbc_pkg::COORD_MAX, psbc_pkg::COORD_MIN, psbc_pkg::COORD_MIN,
                             psbc_pkg::COORD_MIN, 0, 0, 0, psbc_pkg::AXIS_X);

      // directed rows: empty set, extremes, rejections, each major axis, truncation
      dir_table[0]  = mk_row(psbc_pkg::FUNC_REMOVE, 0, 0, 0, 0, 1'b1, empty_reject);
      dir_table[1]  = mk_row(psbc_pkg::FUNC_INSERT, 32767, -32768, 0, 0, 1'b1,
                             summary(1, 1, 32767, -32768, 0, 32767, -32768, 0,
                                     32767, -32768, 0, psbc_pkg::AXIS_X));
      dir_table[2]  = mk_row(psbc_pkg::FUNC_INSERT, -32768, 32767, 0, 1023, 1'b1,
                             summary(1, 2, -32768, -32768, 0, 32767, 32767, 0,
                                     0, 0, 0, psbc_pkg::AXIS_X));
      dir_table[3]  = mk_row(psbc_pkg::FUNC_REMOVE, 0, 0, 0, 2, 1'b1,
                             summary(0, 2, -32768, -32768, 0, 32767, 32767, 0,
                                     0, 0, 0, psbc_pkg::AXIS_X));
      dir_table[4]  = mk_row(psbc_pkg::FUNC_REMOVE, -1, -1, -1, 1023, 1'b1,
                             summary(0, 2, -32768, -32768, 0, 32767, 32767, 0,
                                     0, 0, 0, psbc_pkg::AXIS_X));
      dir_table[5]  = mk_row(psbc_pkg::FUNC_REMOVE, 0, 0, 0, 0, 1'b1,
                             summary(1, 1, -32768, 32767, 0, -32768, 32767, 0,
                                     -32768, 32767, 0, psbc_pkg::AXIS_X));
      dir_table[6]  = mk_row(psbc_pkg::FUNC_REMOVE, 0, 0, 0, 0, 1'b1,
                             summary(1, 0, psbc_pkg::COORD_MAX, psbc_pkg::COORD_MAX,
                                     psbc_pkg::COORD_MAX, psbc_pkg::COORD_MIN,
                                     psbc_pkg::COORD_MIN, psbc_pkg::COORD_MIN,
                                     0, 0, 0, psbc_pkg::AXIS_X));
      dir_table[7]  = mk_row(psbc_pkg::FUNC_INSERT, 0, 0, -32768, 0, 1'b0, '0);
      dir_table[8]  = mk_row(psbc_pkg::FUNC_INSERT, 0, 0, 32767, 0, 1'b0, '0);  // Z widest
      dir_table[9]  = mk_row(psbc_pkg::FUNC_INSERT, 5, -3, 0, 0, 1'b0, '0);
      dir_table[10] = mk_row(psbc_pkg::FUNC_INSERT, 0, 100, 0, 0, 1'b0, '0);
      dir_table[11] = mk_row(psbc_pkg::FUNC_REMOVE, 0, 0, 0, 0, 1'b0, '0);
      dir_table[12] = mk_row(psbc_pkg::FUNC_REMOVE, 0, 0, 0, 0, 1'b0, '0);      // Y widest
      dir_table[13] = mk_row(psbc_pkg::FUNC_INSERT, -7, -1, -1, 0, 1'b0, '0);
      dir_table[14] = mk_row(psbc_pkg::FUNC_INSERT, -8, 0, 0, 0, 1'b0, '0);     // negative mean
      dir_table[15] = mk_row(psbc_pkg::FUNC_REMOVE, 0, 0, 0, 1, 1'b0, '0);      // middle entry
      dir_table[16] = mk_row(psbc_pkg::FUNC_INSERT, 100, -100, 0, 0, 1'b0, '0);
      dir_table[17] = mk_row(psbc_pkg::FUNC_INSERT, -32768, -32768, -32768, 0, 1'b0, '0);
      dir_table[18] = mk_row(psbc_pkg::FUNC_INSERT, 32767, 32767, 32767, 0, 1'b0, '0); // tie
      dir_table[19] = mk_row(psbc_pkg::FUNC_REMOVE, 0, 0, 0, 5, 1'b0, '0);      // last entry
      dir_table[20] = mk_row(psbc_pkg::FUNC_REMOVE, 0, 0, 0, 5, 1'b0, '0);      // out of range

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_idling(3);
      for (int k = 0; k < DIR_ROWS; k++) queue_item(dir_table[k], applied);

      // random part: mostly valid inserts and removes on a small set, some noise
      applied_n = 0;
      for (int phase = 0; phase < 4; phase++) begin
         set_idling(phase);
         while (applied_n < (phase + 1) * RANDOM_ITEMS / 4) begin
            ins_share = (planned_count < 4) ? 80 : ((planned_count > 30) ? 25 : 55);
            if ($urandom_range(99) < 10) begin
               queue_random(1'($urandom_range(1)), int'($urandom_range(1023)), applied);
            end else if (planned_count == 0 || $urandom_range(99) < ins_share) begin
               queue_random(psbc_pkg::FUNC_INSERT, int'($urandom_range(1023)), applied);
            end else begin
               case ($urandom_range(3))
                  0:       pos = 0;
                  1:       pos = planned_count - 1;
                  default: pos = int'($urandom_range(planned_count - 1));
               endcase
               queue_random(psbc_pkg::FUNC_REMOVE, pos, applied);
            end
            if (applied) applied_n++;
         end
      end

      // drain: everything sent, every result back, then a quiet tail
      while (pending_items.size() != 0 || req_valid) @(negedge clock);
      while (expected_summaries.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
